// ===== rtl/mdh_pkg.sv =====
// ----------------------------------------------------------------------------
// mdh_pkg
// Shared types, constants and the octant quantiser for the motion direction
// histogram block.
// ----------------------------------------------------------------------------
package mdh_pkg;

   // field widths
   localparam int CoordWidth = 16;
   localparam int CountWidth = 10;
   localparam int CodeWidth  = 4;
   localparam int BinCount   = 8;
   localparam int BinIdxWidth = $clog2(BinCount);
   localparam int CsrIdxWidth = 4;
   localparam int CsrDataWidth = 16;

   // tan(22.5 deg) in Q16
   localparam logic [14:0] TanQ16 = 15'd27146;

   // codes
   localparam logic [CodeWidth-1:0]  NoDirection = 4'd8;
   localparam logic [CountWidth-1:0] CountMax    = 10'd1023;

   // direction codes, counterclockwise from +x
   localparam logic [CodeWidth-1:0] DirEast      = 4'd0;
   localparam logic [CodeWidth-1:0] DirNorthEast = 4'd1;
   localparam logic [CodeWidth-1:0] DirNorth     = 4'd2;
   localparam logic [CodeWidth-1:0] DirNorthWest = 4'd3;
   localparam logic [CodeWidth-1:0] DirWest      = 4'd4;
   localparam logic [CodeWidth-1:0] DirSouthWest = 4'd5;
   localparam logic [CodeWidth-1:0] DirSouth     = 4'd6;
   localparam logic [CodeWidth-1:0] DirSouthEast = 4'd7;

   localparam logic KindVerdict = 1'b0;
   localparam logic KindReport  = 1'b1;

   // register indexes on the csr port
   localparam logic [CsrIdxWidth-1:0] RegMotionThreshold = 4'd0;
   localparam logic [CsrIdxWidth-1:0] RegReportThreshold = 4'd1;

   // reset values
   localparam logic [CoordWidth-1:0] MotionThresholdReset = 16'd32;
   localparam logic [CountWidth-1:0] ReportThresholdReset = 10'd10;

   // one input word, last field in the lowest bits
   typedef struct packed {
      logic                  last_point;
      logic                  tracked;
      logic [CoordWidth-1:0] start_y;
      logic [CoordWidth-1:0] start_x;
      logic [CoordWidth-1:0] cur_y;
      logic [CoordWidth-1:0] cur_x;
      logic [CoordWidth-1:0] prev_y;
      logic [CoordWidth-1:0] prev_x;
   } item_type;

   // one result word
   typedef struct packed {
      logic                  run_last;
      logic                  above_threshold;
      logic [CountWidth-1:0] bin_count;
      logic [CodeWidth-1:0]  direction_code;
      logic                  kept;
      logic                  report_kind;
   } beat_type;

   typedef logic [BinCount-1:0][CountWidth-1:0] bins_type;

   // absolute difference of two coordinates
   function automatic logic [CoordWidth-1:0] abs_diff(input logic [CoordWidth-1:0] a,
                                                      input logic [CoordWidth-1:0] b);
      return (a > b) ? (a - b) : (b - a);
   endfunction

   // nearest octant of the displacement start -> current; NoDirection if zero
   function automatic logic [CodeWidth-1:0] octant_code(input logic [CoordWidth-1:0] cx,
                                                        input logic [CoordWidth-1:0] cy,
                                                        input logic [CoordWidth-1:0] sx,
                                                        input logic [CoordWidth-1:0] sy);
      logic [CoordWidth-1:0] ax;
      logic [CoordWidth-1:0] ay;
      logic                  xpos;
      logic                  ypos;
      logic [31:0]           ay_sh;
      logic [31:0]           ax_sh;
      logic [31:0]           tan_ax;
      logic [31:0]           tan_ay;
      logic [CodeWidth-1:0]  code;
      ax     = abs_diff(cx, sx);
      ay     = abs_diff(cy, sy);
      xpos   = cx > sx;
      ypos   = cy > sy;
      ay_sh  = {ay, 16'd0};
      ax_sh  = {ax, 16'd0};
      tan_ax = 32'({17'd0, TanQ16} * {16'd0, ax});
      tan_ay = 32'({17'd0, TanQ16} * {16'd0, ay});
      if (ax == '0 && ay == '0) begin
         code = NoDirection;
      end else if (ay_sh < tan_ax) begin
         code = xpos ? DirEast : DirWest;
      end else if (ax_sh < tan_ay) begin
         code = ypos ? DirNorth : DirSouth;
      end else if (ypos) begin
         code = xpos ? DirNorthEast : DirNorthWest;
      end else begin
         code = xpos ? DirSouthEast : DirSouthWest;
      end
      return code;
   endfunction

endpackage

// ===== rtl/motion_direction_histogram.sv =====
// ----------------------------------------------------------------------------
// motion_direction_histogram
// Keeps tracked, moving feature points, quantises their displacement to one
// of eight octants and counts them; reports all eight bins at frame end.
// ----------------------------------------------------------------------------
//  channel  direction  handshake                 payload
//  req      in         req_tvalid / req_tready   tdata positions, tuser tracked,
//                                                tlast last point of frame
//  rsp      out        rsp_tvalid / rsp_tready   tdata verdict or bin report,
//                                                tuser kind, tlast last of item
//  csr      in         csr_valid / csr_ready     csr_index, csr_data
//
//  One point per cycle when neither the output nor a report run stalls: input
//  register, then verdict logic (two constant 16x15 multiplies and compares)
//  into the result register. A frame-end point adds eight report words, sent
//  from a snapshot bank; the input stalls while they are sent. Reset is
//  synchronous and clears valids, counters and thresholds to their defaults.
//  A stalled result holds the input register; csr writes are always taken.
// ----------------------------------------------------------------------------
module motion_direction_histogram (
   input  logic                              clock,
   input  logic                              reset,
   // request
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // prev_x, prev_y, cur_x, cur_y, start_x, start_y
   input  logic [95:0]                       req_tdata,
   // tracked
   input  logic                              req_tuser,
   input  logic                              req_tlast,
   // response
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // kept, direction_code[3:0], bin_count[9:0], above_threshold
   output logic [15:0]                       rsp_tdata,
   // report_kind
   output logic                              rsp_tuser,
   output logic                              rsp_tlast,
   // configuration
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [mdh_pkg::CsrIdxWidth-1:0]   csr_index,
   input  logic [mdh_pkg::CsrDataWidth-1:0]  csr_data
);
   import mdh_pkg::*;

   // registers
   logic                   s1_valid_ff, s1_valid_in;
   item_type               s1_item_ff, s1_item_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   beat_type               rsp_beat_ff, rsp_beat_in;
   logic                   rep_busy_ff, rep_busy_in;
   logic [BinIdxWidth-1:0] rep_idx_ff, rep_idx_in;
   bins_type               bank_ff, bank_in;
   bins_type               cnt_ff, cnt_in;
   logic [CoordWidth-1:0]  motion_thr_ff, motion_thr_in;
   logic [CountWidth-1:0]  report_thr_ff, report_thr_in;

   // verdict datapath
   logic [CoordWidth:0]    motion;
   logic                   kept;
   logic [CodeWidth-1:0]   code;
   logic                   counted;
   logic [BinIdxWidth-1:0] bin_idx;
   logic [CountWidth-1:0]  cnt_old;
   logic [CountWidth-1:0]  cnt_new;
   beat_type               verdict_beat;
   beat_type               report_beat;
   bins_type               cnt_upd;

   // handshake
   logic                   out_free;
   logic                   s1_adv;
   logic                   frame_end;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s1_adv     = out_free && !rep_busy_ff && s1_valid_ff;
   assign frame_end  = s1_adv && s1_item_ff.last_point;
   assign req_tready = !s1_valid_ff || s1_adv;
   assign csr_ready  = 1'b1;

   // point verdict
   always_comb begin
      motion  = {1'b0, abs_diff(s1_item_ff.cur_x, s1_item_ff.prev_x)}
              + {1'b0, abs_diff(s1_item_ff.cur_y, s1_item_ff.prev_y)};
      kept    = s1_item_ff.tracked && (motion > {1'b0, motion_thr_ff});
      code    = kept ? octant_code(s1_item_ff.cur_x, s1_item_ff.cur_y,
                                   s1_item_ff.start_x, s1_item_ff.start_y)
                     : NoDirection;
      counted = kept && (code != NoDirection);
      bin_idx = code[BinIdxWidth-1:0];
      cnt_old = cnt_ff[bin_idx];
      cnt_new = (cnt_old == CountMax) ? cnt_old : cnt_old + 10'd1;

      verdict_beat.report_kind     = KindVerdict;
      verdict_beat.kept            = kept;
      verdict_beat.direction_code  = code;
      verdict_beat.bin_count       = counted ? cnt_new : '0;
      verdict_beat.above_threshold = counted && (cnt_new > report_thr_ff);
      verdict_beat.run_last        = !s1_item_ff.last_point;

      cnt_upd = cnt_ff;
      if (counted) begin
         cnt_upd[bin_idx] = cnt_new;
      end
   end

   // bin report from the snapshot bank
   always_comb begin
      report_beat.report_kind     = KindReport;
      report_beat.kept            = 1'b0;
      report_beat.direction_code  = {1'b0, rep_idx_ff};
      report_beat.bin_count       = bank_ff[rep_idx_ff];
      report_beat.above_threshold = bank_ff[rep_idx_ff] > report_thr_ff;
      report_beat.run_last        = (rep_idx_ff == BinIdxWidth'(BinCount - 1));
   end

   // next state
   always_comb begin
      s1_valid_in   = s1_valid_ff;
      s1_item_in    = s1_item_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_beat_in   = rsp_beat_ff;
      rep_busy_in   = rep_busy_ff;
      rep_idx_in    = rep_idx_ff;
      bank_in       = bank_ff;
      cnt_in        = cnt_ff;
      motion_thr_in = motion_thr_ff;
      report_thr_in = report_thr_ff;

      // input register
      if (req_tready) begin
         s1_valid_in = req_tvalid;
         s1_item_in  = {req_tlast, req_tuser, req_tdata};
      end

      // result register and report sequencer
      if (out_free) begin
         if (rep_busy_ff) begin
            rsp_valid_in = 1'b1;
            rsp_beat_in  = report_beat;
            rep_idx_in   = rep_idx_ff + 1'b1;
            if (rep_idx_ff == BinIdxWidth'(BinCount - 1)) begin
               rep_busy_in = 1'b0;
            end
         end else if (s1_valid_ff) begin
            rsp_valid_in = 1'b1;
            rsp_beat_in  = verdict_beat;
            cnt_in       = cnt_upd;
            if (s1_item_ff.last_point) begin
               bank_in     = cnt_upd;
               cnt_in      = '0;
               rep_busy_in = 1'b1;
               rep_idx_in  = '0;
            end
         end else begin
            rsp_valid_in = 1'b0;
         end
      end

      // configuration writes
      if (csr_valid) begin
         case (csr_index)
            RegMotionThreshold: motion_thr_in = csr_data;
            RegReportThreshold: report_thr_in = csr_data[CountWidth-1:0];
            default: ;
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         rep_busy_ff   <= 1'b0;
         rep_idx_ff    <= '0;
         cnt_ff        <= '0;
         motion_thr_ff <= MotionThresholdReset;
         report_thr_ff <= ReportThresholdReset;
      end else begin
         s1_valid_ff   <= s1_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         rep_busy_ff   <= rep_busy_in;
         rep_idx_ff    <= rep_idx_in;
         cnt_ff        <= cnt_in;
         motion_thr_ff <= motion_thr_in;
         report_thr_ff <= report_thr_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      s1_item_ff  <= s1_item_in;
      rsp_beat_ff <= rsp_beat_in;
      bank_ff     <= bank_in;
   end

   // outputs
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_beat_ff.report_kind;
   assign rsp_tlast  = rsp_beat_ff.run_last;
   assign rsp_tdata  = {rsp_beat_ff.above_threshold, rsp_beat_ff.bin_count,
                        rsp_beat_ff.direction_code, rsp_beat_ff.kept};

`ifndef NO_ASSERTIONS
   // a frame-end verdict starts the report run at bin zero
   a_report_start: assert property (@(posedge clock) disable iff (reset)
      frame_end |=> (rep_busy_ff && rep_idx_ff == '0))
      else $error("report run did not start after frame end");

   // counters are clear right after a frame end
   a_counters_clear: assert property (@(posedge clock) disable iff (reset)
      frame_end |=> (cnt_ff == '0))
      else $error("bin counters not cleared at frame end");

   // no new point enters the output while reports are being sent
   a_no_verdict_in_run: assert property (@(posedge clock) disable iff (reset)
      (rep_busy_ff && out_free) |=> (rsp_valid_ff && rsp_beat_ff.report_kind == KindReport))
      else $error("verdict word interleaved with bin reports");

   // the closing report word carries the last bin
   a_last_report_bin: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_beat_ff.report_kind == KindReport && rsp_beat_ff.run_last)
         |-> (rsp_beat_ff.direction_code == CodeWidth'(BinCount - 1)))
      else $error("report run closed on the wrong bin");
`endif

endmodule
